FILE: rtl/cwkd_pkg.sv
package cwkd_pkg;

  localparam int TIME_W = 63;
  localparam int DLY_W  = 21;  // largest delay 1165 ms in us
  localparam int TAIL_W = 26;  // 65535 ms in us
  localparam int DT_W   = 27;  // delay plus tail, in us

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // frame class, top two bits of the command byte
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_LEN8  = 2'd1;
  localparam logic [1:0] CLS_LEN16 = 2'd2;
  localparam logic [1:0] CLS_RSVD  = 2'd3;

  localparam logic [7:0] REG_MORSE_COMMAND = 8'd0;
  localparam logic [7:0] REG_PTT_TAIL_MS   = 8'd1;

  localparam int MS_TO_US = 1000;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        rx_byte;
    logic [TIME_W-1:0] now_us;
    logic [DLY_W-1:0]  delay_us;
    logic [DT_W-1:0]   step_tail_us;  // delay_us + tail
    logic [TIME_W-1:0] now_tail_us;   // saturated now_us + tail
  } cwkd_item_t;

  // piecewise delay code to microseconds
  function automatic logic [DLY_W-1:0] delay_us(input logic [6:0] code);
    logic [10:0] ms;
    if (code[6]) begin
      ms = 11'd157 + {1'b0, code[5:0], 4'b0000};
    end else if (code[5]) begin
      ms = 11'd32 + {4'b0000, code[4:0], 2'b00};
    end else begin
      ms = {6'b000000, code[4:0]};
    end
    return DLY_W'(32'(ms) * 32'(MS_TO_US));
  endfunction

endpackage

FILE: rtl/cwkd_in_stage.sv
module cwkd_in_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_req_type,
  input  logic [7:0]                   in_rx_byte,
  input  logic [cwkd_pkg::TIME_W-1:0]  in_now_us,
  input  logic [cwkd_pkg::TAIL_W-1:0]  tail_us,
  output logic                         item_valid,
  input  logic                         item_ready,
  output cwkd_pkg::cwkd_item_t         item
);

  logic                        valid_r;
  logic                        valid_nxt;
  cwkd_pkg::cwkd_item_t        item_r;
  cwkd_pkg::cwkd_item_t        item_nxt;
  logic [cwkd_pkg::DLY_W-1:0]  dly;
  logic [cwkd_pkg::TIME_W:0]   now_sum;
  logic                        take;

  assign in_ready = !valid_r || item_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    dly     = cwkd_pkg::delay_us(in_rx_byte[6:0]);
    now_sum = {1'b0, in_now_us} + (cwkd_pkg::TIME_W + 1)'(tail_us);
    item_nxt.req_type     = in_req_type;
    item_nxt.rx_byte      = in_rx_byte;
    item_nxt.now_us       = in_now_us;
    item_nxt.delay_us     = dly;
    item_nxt.step_tail_us = cwkd_pkg::DT_W'(dly) + cwkd_pkg::DT_W'(tail_us);
    item_nxt.now_tail_us  = now_sum[cwkd_pkg::TIME_W] ? cwkd_pkg::TIME_MAX
                                                      : now_sum[cwkd_pkg::TIME_W-1:0];
    valid_nxt = take || (valid_r && !item_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/cwkd_core.sv
module cwkd_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   morse_command,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  cwkd_pkg::cwkd_item_t         item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_key_event_valid,
  output logic                         out_key_press,
  output logic [cwkd_pkg::TIME_W-1:0]  out_key_time_us,
  output logic                         out_ptt_on,
  output logic                         out_parser_stuck
);

  localparam logic [1:0] PH_CMD     = 2'd0;
  localparam logic [1:0] PH_LEN_LO  = 2'd1;
  localparam logic [1:0] PH_LEN_HI  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0]                  phase_r, phase_nxt;
  logic [7:0]                  cmd_r, cmd_nxt;
  logic [15:0]                 remain_r, remain_nxt;
  logic                        stuck_r, stuck_nxt;
  logic [cwkd_pkg::TIME_W-1:0] last_r, last_nxt;
  logic                        set_r, set_nxt;
  logic                        ptt_r, ptt_nxt;
  logic [cwkd_pkg::TIME_W-1:0] deadline_r, deadline_nxt;

  logic                        out_valid_r;
  logic                        ev_r, down_r, ptt_out_r, stuck_out_r;
  logic [cwkd_pkg::TIME_W-1:0] time_r;

  logic                        ev, down;
  logic [cwkd_pkg::TIME_W-1:0] ev_time, t_new, dl_new;
  logic [cwkd_pkg::TIME_W:0]   step_sum, dl_sum;
  logic                        fire;

  assign item_ready = !out_valid_r || out_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    step_sum = {1'b0, last_r} + (cwkd_pkg::TIME_W + 1)'(item.delay_us);
    dl_sum   = {1'b0, last_r} + (cwkd_pkg::TIME_W + 1)'(item.step_tail_us);
    if (!set_r) begin
      t_new  = item.now_us;
      dl_new = item.now_tail_us;
    end else begin
      t_new  = step_sum[cwkd_pkg::TIME_W] ? cwkd_pkg::TIME_MAX
                                          : step_sum[cwkd_pkg::TIME_W-1:0];
      dl_new = dl_sum[cwkd_pkg::TIME_W] ? cwkd_pkg::TIME_MAX
                                        : dl_sum[cwkd_pkg::TIME_W-1:0];
    end

    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    remain_nxt   = remain_r;
    stuck_nxt    = stuck_r;
    last_nxt     = last_r;
    set_nxt      = set_r;
    ptt_nxt      = ptt_r;
    deadline_nxt = deadline_r;
    ev           = 1'b0;
    down         = 1'b0;
    ev_time      = '0;

    if (fire) begin
      case (item.req_type)
        cwkd_pkg::REQ_BYTE: begin
          if (!stuck_r) begin
            case (phase_r)
              PH_CMD: begin
                cmd_nxt = item.rx_byte;
                if (item.rx_byte[7:6] == cwkd_pkg::CLS_RSVD) begin
                  stuck_nxt = 1'b1;
                end else if (item.rx_byte[7:6] != cwkd_pkg::CLS_NONE) begin
                  phase_nxt = PH_LEN_LO;
                end
              end
              PH_LEN_LO: begin
                remain_nxt = {8'd0, item.rx_byte};
                if (cmd_r[7:6] == cwkd_pkg::CLS_LEN16) begin
                  phase_nxt = PH_LEN_HI;
                end else begin
                  phase_nxt = (item.rx_byte != 8'd0) ? PH_PAYLOAD : PH_CMD;
                end
              end
              PH_LEN_HI: begin
                remain_nxt = {item.rx_byte, remain_r[7:0]};
                phase_nxt  = (remain_nxt != 16'd0) ? PH_PAYLOAD : PH_CMD;
              end
              default: begin
                if (cmd_r == morse_command) begin
                  ev       = 1'b1;
                  down     = item.rx_byte[7];
                  last_nxt = t_new;
                  set_nxt  = 1'b1;
                  ev_time  = t_new;
                  if (item.rx_byte[7]) begin
                    ptt_nxt      = 1'b1;
                    deadline_nxt = dl_new;
                  end
                end
                remain_nxt = remain_r - 16'd1;
                if (remain_r == 16'd1) begin
                  phase_nxt = PH_CMD;
                end
              end
            endcase
          end
        end
        cwkd_pkg::REQ_TICK: begin
          if (ptt_r && (item.now_us >= deadline_r)) begin
            ptt_nxt = 1'b0;
          end
        end
        cwkd_pkg::REQ_CLEAR: begin
          phase_nxt  = PH_CMD;
          cmd_nxt    = 8'd0;
          remain_nxt = 16'd0;
          stuck_nxt  = 1'b0;
          last_nxt   = '0;
          set_nxt    = 1'b0;
          ptt_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CMD;
      cmd_r       <= 8'd0;
      remain_r    <= 16'd0;
      stuck_r     <= 1'b0;
      last_r      <= '0;
      set_r       <= 1'b0;
      ptt_r       <= 1'b0;
      deadline_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      remain_r    <= remain_nxt;
      stuck_r     <= stuck_nxt;
      last_r      <= last_nxt;
      set_r       <= set_nxt;
      ptt_r       <= ptt_nxt;
      deadline_r  <= deadline_nxt;
      out_valid_r <= fire || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ev_r        <= ev;
      down_r      <= down;
      time_r      <= ev_time;
      ptt_out_r   <= ptt_nxt;
      stuck_out_r <= stuck_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_key_event_valid = ev_r;
  assign out_key_press       = down_r;
  assign out_key_time_us     = time_r;
  assign out_ptt_on          = ptt_out_r;
  assign out_parser_stuck    = stuck_out_r;

  // once stuck, only a disconnect frees the parser
  a_stuck_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stuck_r && !(fire && item.req_type == cwkd_pkg::REQ_CLEAR) |=> stuck_r)
    else $error("parser left stuck state without disconnect");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.req_type == cwkd_pkg::REQ_CLEAR |=>
      !ptt_r && !stuck_r && !set_r && phase_r == PH_CMD)
    else $error("disconnect did not clear link state");

  a_no_event_when_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ev_r |-> !stuck_out_r)
    else $error("key event reported with parser stuck");

  a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(phase_r) && $stable(ptt_r) && $stable(last_r))
    else $error("state moved without an item");

endmodule

FILE: rtl/cw_frame_key_event_decoder_top.sv
// Morse keying frame decoder with push-to-talk tail timer.
//
// Input channel (in_*): one beat per received stream byte, time tick or
// disconnect, selected by in_req_type; request code 3 changes nothing.
// Output channel (out_*): exactly one result beat per input beat, in order,
// carrying any key event and the PTT and parser-stuck flags after the item.
// Configuration (cfg_*): index 0 is the morse command byte, index 1 the PTT
// tail in ms; write only while no item is in flight. cfg_ready is always high.
//
// Two register stages: an input register that also forms the delay and tail
// sums, then the state update and the result register. An accepted input
// waits in the input register, then its result waits in the result register
// under out_valid. One item per cycle is sustained while out_ready stays
// high; the state update loops back through the state registers, so each
// item sees the state its predecessor left. A stalled receiver holds the
// result register, then the input register, and in_ready drops only when
// both are full. Reset (rst_n low, synchronous) clears parser, times, PTT
// and the valid flags of both registers; in_ready is high once it ends.
module cw_frame_key_event_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_rx_byte,
  input  logic [62:0] in_now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_key_event_valid,
  output logic        out_key_press,
  output logic [62:0] out_key_time_us,
  output logic        out_ptt_on,
  output logic        out_parser_stuck,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]                  morse_cmd_r;
  logic [cwkd_pkg::TAIL_W-1:0] tail_us_r;
  logic                        item_valid;
  logic                        item_ready;
  cwkd_pkg::cwkd_item_t        item;
  logic                        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // tail kept in microseconds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      morse_cmd_r <= 8'd0;
      tail_us_r   <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == cwkd_pkg::REG_MORSE_COMMAND) begin
        morse_cmd_r <= cfg_data[7:0];
      end else if (cfg_index == cwkd_pkg::REG_PTT_TAIL_MS) begin
        tail_us_r <= cwkd_pkg::TAIL_W'(32'(cfg_data) * 32'(cwkd_pkg::MS_TO_US));
      end
    end
  end

  cwkd_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_rx_byte  (in_rx_byte),
    .in_now_us   (in_now_us),
    .tail_us     (tail_us_r),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item)
  );

  cwkd_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .morse_command       (morse_cmd_r),
    .item_valid          (item_valid),
    .item_ready          (item_ready),
    .item                (item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_key_event_valid (out_key_event_valid),
    .out_key_press       (out_key_press),
    .out_key_time_us     (out_key_time_us),
    .out_ptt_on          (out_ptt_on),
    .out_parser_stuck    (out_parser_stuck)
  );

endmodule

FILE: tb/tb_cw_frame_key_event_decoder_top.sv
`timescale 1ns / 1ps

module tb_cw_frame_key_event_decoder_top;

  localparam logic [1:0] REQ_IDLE = 2'd3;  // no operation
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 80;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD
  } parse_phase_t;

  typedef struct packed {
    logic        event_valid;
    logic        key_press;
    logic [62:0] key_time_us;
    logic        ptt_on;
    logic        parser_stuck;
  } key_result_t;

  class key_event_sb_t;
    logic [7:0]   morse_cmd;
    logic [15:0]  tail_ms;
    parse_phase_t phase;
    logic [7:0]   cur_cmd;
    logic [15:0]  remaining;
    logic         stuck;
    logic [62:0]  key_time;
    logic         time_set;
    logic         ptt;
    logic [62:0]  deadline;
    key_result_t  pending[$];
    int           errors;
    int           items;
    int           events;
    int           ptt_drops;

    function new();
      morse_cmd = '0;
      tail_ms   = '0;
      deadline  = '0;
      errors    = 0;
      items     = 0;
      events    = 0;
      ptt_drops = 0;
      clear_link();
    endfunction

    function void clear_link();
      phase     = PH_CMD;
      cur_cmd   = '0;
      remaining = '0;
      stuck     = 1'b0;
      key_time  = '0;
      time_set  = 1'b0;
      ptt       = 1'b0;
    endfunction

    function logic [62:0] sat_add(logic [62:0] a, logic [63:0] b);
      logic [63:0] s;
      s = {1'b0, a} + b;
      return (s > {1'b0, cwkd_pkg::TIME_MAX}) ? cwkd_pkg::TIME_MAX : s[62:0];
    endfunction

    function logic [10:0] delay_ms(logic [6:0] code);
      if (code <= 7'h1F) return 11'(code);
      if (code <= 7'h3F) return 11'd32 + 11'd4 * 11'(code - 7'h20);
      return 11'd157 + 11'd16 * 11'(code - 7'h40);
    endfunction

    function void set_reg(logic [7:0] idx, logic [15:0] val);
      if (idx == cwkd_pkg::REG_MORSE_COMMAND) morse_cmd = val[7:0];
      else if (idx == cwkd_pkg::REG_PTT_TAIL_MS) tail_ms = val;
    endfunction

    function void note_item(logic [1:0] req, logic [7:0] b, logic [62:0] now);
      key_result_t r;
      r = '0;
      items++;
      if (req == cwkd_pkg::REQ_BYTE && !stuck) begin
        case (phase)
          PH_CMD: begin
            cur_cmd = b;
            if (b[7:6] == cwkd_pkg::CLS_RSVD) stuck = 1'b1;
            else if (b[7:6] != cwkd_pkg::CLS_NONE) phase = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            remaining = {8'h00, b};
            if (cur_cmd[7:6] == cwkd_pkg::CLS_LEN16) phase = PH_LEN_HI;
            else phase = (b != 8'h00) ? PH_PAYLOAD : PH_CMD;
          end
          PH_LEN_HI: begin
            remaining[15:8] = b;
            phase = (remaining != 16'h0000) ? PH_PAYLOAD : PH_CMD;
          end
          default: begin
            if (cur_cmd == morse_cmd) begin
              r.event_valid = 1'b1;
              r.key_press = b[7];
              if (!time_set) begin
                key_time = now;
                time_set = 1'b1;
              end else begin
                key_time = sat_add(key_time, 64'(delay_ms(b[6:0])) * 64'd1000);
              end
              r.key_time_us = key_time;
              events++;
              if (b[7]) begin
                ptt = 1'b1;
                deadline = sat_add(key_time, 64'(tail_ms) * 64'd1000);
              end
            end
            remaining = remaining - 16'd1;
            if (remaining == 16'h0000) phase = PH_CMD;
          end
        endcase
      end else if (req == cwkd_pkg::REQ_TICK) begin
        if (ptt && now >= deadline) begin
          ptt = 1'b0;
          ptt_drops++;
        end
      end else if (req == cwkd_pkg::REQ_CLEAR) begin
        clear_link();
      end
      r.ptt_on = ptt;
      r.parser_stuck = stuck;
      pending.push_back(r);
    endfunction

    function void check_result(key_result_t got);
      key_result_t exp;
      if (pending.size() == 0) begin
        $error("result beat with nothing outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.event_valid !== exp.event_valid) begin
        $error("key_event_valid: expected %0d, got %0d", exp.event_valid, got.event_valid);
        errors++;
      end
      if (got.key_press !== exp.key_press) begin
        $error("key_press: expected %0d, got %0d", exp.key_press, got.key_press);
        errors++;
      end
      if (got.key_time_us !== exp.key_time_us) begin
        $error("key_time_us: expected %0d, got %0d", exp.key_time_us, got.key_time_us);
        errors++;
      end
      if (got.ptt_on !== exp.ptt_on) begin
        $error("ptt_on: expected %0d, got %0d", exp.ptt_on, got.ptt_on);
        errors++;
      end
      if (got.parser_stuck !== exp.parser_stuck) begin
        $error("parser_stuck: expected %0d, got %0d", exp.parser_stuck, got.parser_stuck);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = cwkd_pkg::REQ_BYTE;
  logic [7:0]  in_rx_byte = '0;
  logic [62:0] in_now_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_key_event_valid;
  logic        out_key_press;
  logic [62:0] out_key_time_us;
  logic        out_ptt_on;
  logic        out_parser_stuck;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  key_event_sb_t sb;
  bit          steady = 1'b0;
  logic [62:0] wall_us = 63'd1000;
  int          settings = 0;
  int          stall_cycles = 0;

  logic [7:0]  cmd_set[PHASES]  = '{8'h41, 8'h00, 8'h85, 8'hFF, 8'h7F, 8'hBF};
  logic [15:0] tail_set[PHASES] = '{16'd2, 16'd65535, 16'd0, 16'd100, 16'd1, 16'd700};

  cw_frame_key_event_decoder_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_rx_byte          (in_rx_byte),
    .in_now_us           (in_now_us),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_key_event_valid (out_key_event_valid),
    .out_key_press       (out_key_press),
    .out_key_time_us     (out_key_time_us),
    .out_ptt_on          (out_ptt_on),
    .out_parser_stuck    (out_parser_stuck),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_key_event_valid, out_key_press, out_key_time_us,
                       out_ptt_on, out_parser_stuck});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_cw_frame_key_event_decoder_top: errors");
      $finish;
    end
  end

  function automatic logic [62:0] next_now();
    logic [63:0] t;
    t = {1'b0, wall_us} + 64'($urandom_range(0, 300000));
    wall_us = (t > {1'b0, cwkd_pkg::TIME_MAX}) ? cwkd_pkg::TIME_MAX : t[62:0];
    return wall_us;
  endfunction

  function automatic logic [62:0] any_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  // every task enters and leaves at a falling edge with nothing yet driven there
  task automatic send_item(input logic [1:0] req, input logic [7:0] b, input logic [62:0] now);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_rx_byte  <= b;
    in_now_us   <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(req, b, now);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(cwkd_pkg::REQ_BYTE, b, next_now());
  endtask

  task automatic pause_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(input logic [7:0] cmd, input logic [15:0] tail);
    cfg_valid <= 1'b1;
    cfg_index <= cwkd_pkg::REG_MORSE_COMMAND;
    cfg_data  <= {8'h00, cmd};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(cwkd_pkg::REG_MORSE_COMMAND, {8'h00, cmd});
    @(negedge clk);
    cfg_index <= cwkd_pkg::REG_PTT_TAIL_MS;
    cfg_data  <= tail;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(cwkd_pkg::REG_PTT_TAIL_MS, tail);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    settings++;
  endtask

  // one frame, mostly well formed; some are cut short and closed by a disconnect
  task automatic send_frame();
    logic [7:0]  cmd;
    logic [15:0] len;
    int          n;
    int          cut;
    if ($urandom_range(0, 99) < 75) cmd = sb.morse_cmd;
    else cmd = 8'($urandom_range(8'h40, 8'hBF));
    send_byte(cmd);
    if (cmd[7:6] == cwkd_pkg::CLS_NONE || cmd[7:6] == cwkd_pkg::CLS_RSVD) return;
    len = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
    if (cmd[7:6] == cwkd_pkg::CLS_LEN16 && $urandom_range(0, 29) == 0) begin
      len[15:8] = 8'($urandom_range(1, 255));
    end
    send_byte(len[7:0]);
    if (cmd[7:6] == cwkd_pkg::CLS_LEN16) send_byte(len[15:8]);
    n = (len > 16'd12) ? 12 : int'(len);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n;
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item($urandom_range(0, 1) ? cwkd_pkg::REQ_TICK : REQ_IDLE, 8'($urandom),
                  next_now());
      end
      send_byte(8'($urandom));
    end
    if (cut < int'(len)) send_item(cwkd_pkg::REQ_CLEAR, 8'($urandom), next_now());
  endtask

  task automatic run_random_phase(input int target);
    int start;
    int pick;
    bit paused;
    start = sb.items;
    paused = 1'b0;
    while (sb.items - start < target) begin
      if (!paused && sb.items - start >= target / 2) begin
        pause_for_results();
        paused = 1'b1;
      end
      // resync: a stuck or misaligned parser gets a disconnect most of the time
      if ((sb.stuck || sb.phase != PH_CMD) && $urandom_range(0, 9) < 7) begin
        send_item(cwkd_pkg::REQ_CLEAR, 8'($urandom), next_now());
      end
      pick = $urandom_range(0, 99);
      if (pick < 66) send_frame();
      else if (pick < 74) send_item(cwkd_pkg::REQ_TICK, 8'($urandom), next_now());
      else if (pick < 80) send_item(cwkd_pkg::REQ_TICK, 8'($urandom),
                                    sb.deadline - 63'($urandom_range(0, 1)));
      else if (pick < 84) send_item(cwkd_pkg::REQ_TICK, 8'($urandom), any_time());
      else if (pick < 88) send_item(REQ_IDLE, 8'($urandom), any_time());
      else if (pick < 92) send_item(cwkd_pkg::REQ_CLEAR, 8'($urandom), any_time());
      else if (pick < 96) send_item(cwkd_pkg::REQ_BYTE, 8'($urandom), any_time());
      else send_byte(8'($urandom_range(8'hC0, 8'hFF)));
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_config(8'h41, 16'd3);

    // morse frame, 8-bit length: first event takes now; low and high delay ranges
    send_item(cwkd_pkg::REQ_BYTE, 8'h41, 63'd1000);
    send_item(cwkd_pkg::REQ_BYTE, 8'h03, 63'd1000);
    send_item(cwkd_pkg::REQ_BYTE, 8'h80, 63'd5000);
    send_item(cwkd_pkg::REQ_BYTE, 8'h1F, 63'd6000);
    send_item(cwkd_pkg::REQ_BYTE, 8'hFF, 63'd6000);
    // tick just before and exactly at the deadline, then with PTT already off
    send_item(cwkd_pkg::REQ_TICK, 8'h00, 63'd1203999);
    send_item(cwkd_pkg::REQ_TICK, 8'h00, 63'd1204000);
    send_item(cwkd_pkg::REQ_TICK, 8'hFF, 63'd0);
    // zero-length frame and a no-payload command
    send_item(cwkd_pkg::REQ_BYTE, 8'h41, 63'd2000000);
    send_item(cwkd_pkg::REQ_BYTE, 8'h00, 63'd2000000);
    send_item(cwkd_pkg::REQ_BYTE, 8'h3F, 63'd2000000);
    // 16-bit length frame of another command: payload ignored
    send_item(cwkd_pkg::REQ_BYTE, 8'h81, 63'd2000000);
    send_item(cwkd_pkg::REQ_BYTE, 8'h01, 63'd2000000);
    send_item(cwkd_pkg::REQ_BYTE, 8'h00, 63'd2000000);
    send_item(cwkd_pkg::REQ_BYTE, 8'hAA, 63'd2000000);
    send_item(REQ_IDLE, 8'hC3, cwkd_pkg::TIME_MAX);
    send_item(cwkd_pkg::REQ_CLEAR, 8'h00, 63'd0);
    // first event at time zero, next adds its delay to zero
    send_item(cwkd_pkg::REQ_BYTE, 8'h41, 63'd0);
    send_item(cwkd_pkg::REQ_BYTE, 8'h02, 63'd0);
    send_item(cwkd_pkg::REQ_BYTE, 8'h20, 63'd0);
    send_item(cwkd_pkg::REQ_BYTE, 8'hBF, 63'd0);
    // reserved encoding blocks the parser until disconnect
    send_item(cwkd_pkg::REQ_BYTE, 8'hC0, 63'd10);
    send_item(cwkd_pkg::REQ_BYTE, 8'h41, 63'd10);
    send_item(cwkd_pkg::REQ_TICK, 8'h00, cwkd_pkg::TIME_MAX);
    send_item(cwkd_pkg::REQ_CLEAR, 8'h00, 63'd10);
    // event time and deadline saturate
    send_item(cwkd_pkg::REQ_BYTE, 8'h41, cwkd_pkg::TIME_MAX);
    send_item(cwkd_pkg::REQ_BYTE, 8'h02, cwkd_pkg::TIME_MAX);
    send_item(cwkd_pkg::REQ_BYTE, 8'hC0, cwkd_pkg::TIME_MAX - 63'd5);
    send_item(cwkd_pkg::REQ_BYTE, 8'hFF, cwkd_pkg::TIME_MAX);
    send_item(cwkd_pkg::REQ_TICK, 8'h00, cwkd_pkg::TIME_MAX);
    send_item(cwkd_pkg::REQ_CLEAR, 8'h00, 63'd0);
    pause_for_results();

    for (int p = 0; p < PHASES; p++) begin
      steady = (p == 2);
      write_config(cmd_set[p], tail_set[p]);
      run_random_phase(PHASE_ITEMS);
      pause_for_results();
    end
    steady = 1'b0;

    repeat (8) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d result beats never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("covered %0d items over %0d register settings", sb.items, settings);
    $display("key events %0d, PTT tail expiries %0d", sb.events, sb.ptt_drops);
    if (sb.errors == 0) begin
      $display("tb_cw_frame_key_event_decoder_top: clean");
    end else begin
      $display("tb_cw_frame_key_event_decoder_top: errors");
    end
    $finish;
  end

endmodule
